/* hw/rtl/tdseg_pkg.sv */
// Shared types and constants for the transmit ring DMA segmenter.
package tdseg_pkg;

   // Field widths fixed by the channel definitions.
   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int FIDX_W = 10;
   localparam int POS_W  = 10;
   localparam int DROP_W = 32;

   // Command codes on the request channel.
   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DONE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ERROR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FETCH = 2'd3;

   // Operation kinds after classification by the front end.
   typedef enum logic [2:0] {
      OP_PUSH,
      OP_REFUSED,
      OP_DONE,
      OP_ERROR,
      OP_FETCH
   } op_kind_type;

   // One classified operation as it travels through the queue.
   typedef struct packed {
      op_kind_type       kind;
      logic [BYTE_W-1:0] byte_value;
      logic              last_of_call;
   } op_type;

endpackage

/* hw/rtl/tdseg_req_if.sv */
// Request channel interface: command, byte and fetch index with valid/ready.
interface tdseg_req_if;
   import tdseg_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] byte_value;
   logic              last_of_call;
   logic [FIDX_W-1:0] fetch_index;

   modport source (output valid, command, byte_value, last_of_call, fetch_index,
                   input ready);
   modport sink   (input valid, command, byte_value, last_of_call, fetch_index,
                   output ready);
endinterface

/* hw/rtl/tdseg_rsp_if.sv */
// Response channel interface: status, DMA launch, drop count and fetched byte.
interface tdseg_rsp_if;
   import tdseg_pkg::*;

   logic              valid;
   logic              ready;
   logic              status;
   logic              dma_start;
   logic [POS_W-1:0]  dma_offset;
   logic [POS_W-1:0]  dma_length;
   logic [DROP_W-1:0] dropped_total;
   logic [BYTE_W-1:0] fetched_byte;

   modport source (output valid, status, dma_start, dma_offset, dma_length,
                   dropped_total, fetched_byte, input ready);
   modport sink   (input valid, status, dma_start, dma_offset, dma_length,
                   dropped_total, fetched_byte, output ready);
endinterface

/* hw/rtl/tdseg_ram.sv */
// Generic single-port RAM with registered read data.
module tdseg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port share one address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/tdseg_front.sv */
// Front end: takes request transfers, holds the enable register, classifies items.
module tdseg_front #(
   parameter int RING_DEPTH = 1024,
   localparam int PTR_W = $clog2(RING_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   tdseg_req_if.sink          req_chan,
   output logic               op_valid,
   input  logic               op_ready,
   output tdseg_pkg::op_type  op,
   output logic [PTR_W-1:0]   op_index
);
   import tdseg_pkg::*;

   // Number of conditional subtract steps that fold a fetch index into the ring.
   // A power-of-two depth needs none: truncation already does it.
   function automatic int fold_steps_f(int depth);
      int steps;
      steps = 0;
      if ((depth & (depth - 1)) != 0) begin
         for (int i = 0; i <= FIDX_W; i++) begin
            if ((depth << i) < (1 << FIDX_W)) begin
               steps = i + 1;
            end
         end
      end
      return steps;
   endfunction

   function automatic int fold_top_f(int depth, int steps);
      int top;
      top = 0;
      if (steps != 0) begin
         top = depth << (steps - 1);
      end
      return top;
   endfunction

   localparam int FOLD_STEPS = fold_steps_f(RING_DEPTH);
   localparam int CNT_W = (FOLD_STEPS < 1) ? 1 : $clog2(FOLD_STEPS + 1);
   localparam logic [FIDX_W-1:0] FOLD_TOP = FIDX_W'(fold_top_f(RING_DEPTH, FOLD_STEPS));
   localparam logic [CNT_W-1:0]  FOLD_CNT = CNT_W'(FOLD_STEPS);

   typedef enum logic [1:0] {
      ST_PASS = 2'b01,
      ST_FOLD = 2'b10
   } fe_state_type;

   fe_state_type      state_ff, state_in;
   logic              enabled_ff;
   op_type            cur_op;
   logic              need_fold;
   op_type            fold_op_ff, fold_op_in;
   logic [FIDX_W-1:0] fold_val_ff, fold_val_in;
   logic [FIDX_W-1:0] fold_div_ff, fold_div_in;
   logic [CNT_W-1:0]  fold_cnt_ff, fold_cnt_in;

   // Enable register; pushes are refused while it is clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_write_enable) begin
         enabled_ff <= csr_write_data;
      end
   end

   // Classify the incoming item.
   always_comb begin
      cur_op.byte_value   = req_chan.byte_value;
      cur_op.last_of_call = req_chan.last_of_call;
      unique case (req_chan.command)
         CMD_PUSH:  cur_op.kind = enabled_ff ? OP_PUSH : OP_REFUSED;
         CMD_DONE:  cur_op.kind = OP_DONE;
         CMD_ERROR: cur_op.kind = OP_ERROR;
         CMD_FETCH: cur_op.kind = OP_FETCH;
      endcase
   end

   assign need_fold = (FOLD_STEPS != 0) && (req_chan.command == CMD_FETCH);

   // Hand items to the queue, folding out-of-ring fetch indexes first.
   always_comb begin
      state_in       = state_ff;
      fold_op_in     = fold_op_ff;
      fold_val_in    = fold_val_ff;
      fold_div_in    = fold_div_ff;
      fold_cnt_in    = fold_cnt_ff;
      req_chan.ready = 1'b0;
      op_valid       = 1'b0;
      op             = cur_op;
      op_index       = PTR_W'(req_chan.fetch_index);
      unique case (state_ff)
         ST_PASS: begin
            req_chan.ready = op_ready;
            op_valid       = req_chan.valid && !need_fold;
            if (req_chan.valid && op_ready && need_fold) begin
               state_in    = ST_FOLD;
               fold_op_in  = cur_op;
               fold_val_in = req_chan.fetch_index;
               fold_div_in = FOLD_TOP;
               fold_cnt_in = FOLD_CNT;
            end
         end
         ST_FOLD: begin
            op       = fold_op_ff;
            op_index = PTR_W'(fold_val_ff);
            if (fold_cnt_ff != '0) begin
               if (fold_val_ff >= fold_div_ff) begin
                  fold_val_in = fold_val_ff - fold_div_ff;
               end
               fold_div_in = fold_div_ff >> 1;
               fold_cnt_in = fold_cnt_ff - 1'b1;
            end else begin
               op_valid = 1'b1;
               if (op_ready) begin
                  state_in = ST_PASS;
               end
            end
         end
         default: begin
            state_in = ST_PASS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PASS;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      fold_op_ff  <= fold_op_in;
      fold_val_ff <= fold_val_in;
      fold_div_ff <= fold_div_in;
      fold_cnt_ff <= fold_cnt_in;
   end
endmodule

/* hw/rtl/tdseg_queue.sv */
// Small register queue that decouples the front end from the back end.
module tdseg_queue #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = data_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

/* hw/rtl/tdseg_back.sv */
// Back end: ring pointers, DMA segment launch, drop counter and response register.
module tdseg_back #(
   parameter int RING_DEPTH = 1024,
   localparam int PTR_W = $clog2(RING_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   output logic              op_ready,
   input  tdseg_pkg::op_type op,
   input  logic [PTR_W-1:0]  op_index,
   tdseg_rsp_if.source       rsp_chan
);
   import tdseg_pkg::*;

   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(RING_DEPTH);

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic              busy_ff, busy_in, busy_mid;
   logic [PTR_W-1:0]  seg_len_ff, seg_len_in;
   logic [DROP_W-1:0] drop_ff, drop_in;
   logic              rsp_valid_ff;
   logic              status_ff, status_in;
   logic              start_ff, start_in;
   logic [POS_W-1:0]  offset_ff, offset_in;
   logic [POS_W-1:0]  length_ff, length_in;
   logic              fetch_sel_ff;
   logic              take;
   logic [PTR_W-1:0]  head_inc;
   logic              ring_full;
   logic [PTR_W:0]    tail_sum;
   logic [PTR_W-1:0]  tail_adv;
   logic              try_launch;
   logic              can_launch;
   logic [PTR_W-1:0]  seg_n;
   logic              ram_wr, ram_rd;
   logic [PTR_W-1:0]  ram_addr;
   logic [BYTE_W-1:0] ram_data;

   assign op_ready = !rsp_valid_ff || rsp_chan.ready;
   assign take     = op_valid && op_ready;

   // Next head with wrap, and the tail after a completed segment.
   assign head_inc  = (head_ff == LAST_POS) ? '0 : PTR_W'(head_ff + 1'b1);
   assign ring_full = head_inc == tail_ff;
   assign tail_sum  = (PTR_W + 1)'(tail_ff) + (PTR_W + 1)'(seg_len_ff);
   assign tail_adv  = (tail_sum >= DEPTH_X) ? PTR_W'(tail_sum - DEPTH_X) : PTR_W'(tail_sum);

   // Execute one operation against the ring state.
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      busy_mid   = busy_ff;
      drop_in    = drop_ff;
      try_launch = 1'b0;
      status_in  = 1'b0;
      ram_wr     = 1'b0;
      ram_rd     = 1'b0;
      ram_addr   = head_ff;
      unique case (op.kind)
         OP_PUSH: begin
            if (ring_full) begin
               drop_in = drop_ff + DROP_W'(1);
            end else begin
               ram_wr  = take;
               head_in = head_inc;
            end
            try_launch = op.last_of_call;
         end
         OP_REFUSED: begin
            status_in = 1'b1;
         end
         OP_DONE: begin
            if (busy_ff) begin
               tail_in  = tail_adv;
               busy_mid = 1'b0;
            end
            try_launch = 1'b1;
         end
         OP_ERROR: begin
            busy_mid   = 1'b0;
            try_launch = 1'b1;
         end
         OP_FETCH: begin
            ram_rd   = take;
            ram_addr = op_index;
         end
         default: begin
         end
      endcase
   end

   // Segment launch: tail to head, or tail to the end of the ring once head wrapped.
   always_comb begin
      can_launch = try_launch && !busy_mid && (head_in != tail_in);
      if (head_in > tail_in) begin
         seg_n = head_in - tail_in;
      end else begin
         seg_n = PTR_W'(DEPTH_X - (PTR_W + 1)'(tail_in));
      end
      busy_in    = can_launch ? 1'b1 : busy_mid;
      seg_len_in = can_launch ? seg_n : seg_len_ff;
      start_in   = can_launch;
      offset_in  = can_launch ? POS_W'(tail_in) : '0;
      length_in  = can_launch ? POS_W'(seg_n) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         busy_ff      <= 1'b0;
         seg_len_ff   <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            head_ff    <= head_in;
            tail_ff    <= tail_in;
            busy_ff    <= busy_in;
            seg_len_ff <= seg_len_in;
            drop_ff    <= drop_in;
         end
         if (op_ready) begin
            rsp_valid_ff <= op_valid;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (take) begin
         status_ff    <= status_in;
         start_ff     <= start_in;
         offset_ff    <= offset_in;
         length_ff    <= length_in;
         fetch_sel_ff <= op.kind == OP_FETCH;
      end
   end

   tdseg_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr),
      .rd_en   (ram_rd),
      .addr    (ram_addr),
      .wr_data (op.byte_value),
      .rd_data (ram_data)
   );

   // The RAM read data holds until the next fetch, which waits for this transfer.
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.dma_start     = start_ff;
   assign rsp_chan.dma_offset    = offset_ff;
   assign rsp_chan.dma_length    = length_ff;
   assign rsp_chan.dropped_total = drop_ff;
   assign rsp_chan.fetched_byte  = fetch_sel_ff ? ram_data : '0;
endmodule

/* hw/rtl/tx_ring_dma_segmenter_unit.sv */
// Top level of the transmit ring DMA segmenter.
//
//  Channel   Direction  Carries
//  req_chan  in         command, byte_value, last_of_call, fetch_index
//  rsp_chan  out        status, dma_start, dma_offset, dma_length,
//                       dropped_total, fetched_byte
//  csr_*     in         enabled register write, no read-back
//
// Pushes and DMA events run at one item per cycle while neither the queue nor the
// response channel stalls; a result is written into the queue at its request
// transfer and then executed by the back end into the response register.
// A fetch whose index must be folded into a ring of non-power-of-two depth
// is held in the front end for its fold steps and its hand-off to the queue, and
// no request is taken meanwhile (no fold steps for 1024 entries).
// Reset clears pointers, busy flag and drop counter; ring bytes are undefined
// until written, so there is no clearing pass.
// A stalled response holds the back end; the front keeps taking items until
// the queue of QUEUE_DEPTH entries fills.
module tx_ring_dma_segmenter_unit #(
   parameter int RING_DEPTH  = 1024,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   tdseg_req_if.sink   req_chan,
   tdseg_rsp_if.source rsp_chan
);
   import tdseg_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int Q_W   = $bits(op_type) + PTR_W;

   logic             fe_valid, fe_ready;
   op_type           fe_op;
   logic [PTR_W-1:0] fe_index;
   logic             be_valid, be_ready;
   op_type           be_op;
   logic [PTR_W-1:0] be_index;
   logic [Q_W-1:0]   q_push_data, q_pop_data;

   tdseg_front #(
      .RING_DEPTH (RING_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .op_valid         (fe_valid),
      .op_ready         (fe_ready),
      .op               (fe_op),
      .op_index         (fe_index)
   );

   // Pack the classified operation and its ring index into one queue entry.
   assign q_push_data       = {fe_op, fe_index};
   assign {be_op, be_index} = q_pop_data;

   tdseg_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (fe_ready),
      .push_data  (q_push_data),
      .pop_valid  (be_valid),
      .pop_ready  (be_ready),
      .pop_data   (q_pop_data)
   );

   tdseg_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (be_valid),
      .op_ready (be_ready),
      .op       (be_op),
      .op_index (be_index),
      .rsp_chan (rsp_chan)
   );
endmodule

/* hw/rtl/tdseg_checker.sv */
// Port-level checker for the segmenter, bound to the top level.
module tdseg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_status,
   input logic                          rsp_dma_start,
   input logic [tdseg_pkg::POS_W-1:0]   rsp_dma_offset,
   input logic [tdseg_pkg::POS_W-1:0]   rsp_dma_length,
   input logic [tdseg_pkg::DROP_W-1:0]  rsp_dropped_total,
   input logic [tdseg_pkg::BYTE_W-1:0]  rsp_fetched_byte
);
   import tdseg_pkg::*;

   // A response that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dropped_total) && $stable(rsp_dma_offset)
         && $stable(rsp_dma_length) && $stable(rsp_fetched_byte))
      else $error("response payload changed while stalled");

   // A refused push launches nothing and returns no byte.
   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_dma_start && (rsp_fetched_byte == '0))
      else $error("refused push carried a launch or data");

   // Without a launch the segment fields read zero.
   a_no_launch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dma_start |-> (rsp_dma_offset == '0) && (rsp_dma_length == '0))
      else $error("segment fields set without a launch");

   // Reset empties the response register.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind tx_ring_dma_segmenter_unit tdseg_checker u_tdseg_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_dma_start     (rsp_chan.dma_start),
   .rsp_dma_offset    (rsp_chan.dma_offset),
   .rsp_dma_length    (rsp_chan.dma_length),
   .rsp_dropped_total (rsp_chan.dropped_total),
   .rsp_fetched_byte  (rsp_chan.fetched_byte)
);

/* dv/tb.sv */
// Self-checking testbench for the transmit ring DMA segmenter top level.
`timescale 1ns / 100ps

module tb;
   import tdseg_pkg::*;

   localparam int RING_SLOTS     = 1024;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;

   // One expected or observed result transfer.
   typedef struct packed {
      logic              status;
      logic              dma_start;
      logic [POS_W-1:0]  dma_offset;
      logic [POS_W-1:0]  dma_length;
      logic [DROP_W-1:0] dropped_total;
      logic [BYTE_W-1:0] fetched_byte;
   } tx_result_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   tdseg_req_if req_chan ();
   tdseg_rsp_if rsp_chan ();

   tx_ring_dma_segmenter_unit #(
      .RING_DEPTH (RING_SLOTS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   // Shadow copy of the ring, its pointers and the DMA bookkeeping.
   logic [BYTE_W-1:0] tx_ring [RING_SLOTS];
   bit                slot_written [RING_SLOTS];
   int                written_slots [$];
   logic [POS_W-1:0]  ring_head;
   logic [POS_W-1:0]  ring_tail;
   logic              dma_active;
   logic [POS_W:0]    active_len;
   logic [DROP_W-1:0] drop_count;
   logic              port_enabled;

   tx_result_type expected_results [$];
   int            mismatch_count;
   int            send_idle_pct;
   int            recv_idle_pct;
   int            rsp_hold_cycles;
   int            quiet_cycles;

   // Free-running clock, 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Launch the pending segment if the DMA engine is free.
   function automatic void launch_segment(inout tx_result_type r);
      logic [POS_W:0] n;
      if (dma_active || ring_head == ring_tail) begin
         return;
      end
      if (ring_head > ring_tail) begin
         n = (POS_W+1)'(ring_head - ring_tail);
      end else begin
         n = (POS_W+1)'(RING_SLOTS) - (POS_W+1)'(ring_tail);
      end
      dma_active   = 1'b1;
      active_len   = n;
      r.dma_start  = 1'b1;
      r.dma_offset = ring_tail;
      r.dma_length = n[POS_W-1:0];
   endfunction

   // Advance the shadow state by one accepted request and queue its result.
   task automatic predict_result(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                                 input logic last, input logic [FIDX_W-1:0] fidx);
      tx_result_type    r;
      logic [POS_W-1:0] next_head;
      r = '0;
      case (cmd)
         CMD_PUSH: begin
            if (!port_enabled) begin
               r.status = 1'b1;
            end else begin
               next_head = ring_head + 1'b1;
               if (next_head == ring_tail) begin
                  drop_count = drop_count + 1'b1;
               end else begin
                  tx_ring[ring_head] = b;
                  if (!slot_written[ring_head]) begin
                     slot_written[ring_head] = 1'b1;
                     written_slots.push_back(int'(ring_head));
                  end
                  ring_head = next_head;
               end
               if (last) begin
                  launch_segment(r);
               end
            end
         end
         CMD_DONE: begin
            if (dma_active) begin
               ring_tail  = POS_W'(ring_tail + active_len);
               dma_active = 1'b0;
            end
            launch_segment(r);
         end
         CMD_ERROR: begin
            dma_active = 1'b0;
            launch_segment(r);
         end
         default: begin
            r.fetched_byte = tx_ring[fidx];
         end
      endcase
      r.dropped_total = drop_count;
      expected_results.push_back(r);
   endtask

   // Offer one request, idling at random first, and wait for its transfer.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                            input logic last, input logic [FIDX_W-1:0] fidx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.byte_value   <= b;
      req_chan.last_of_call <= last;
      req_chan.fetch_index  <= fidx;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      predict_result(cmd, b, last, fidx);
   endtask

   task automatic push_byte(input logic last);
      send_item(CMD_PUSH, BYTE_W'($urandom_range(0, 255)), last,
                FIDX_W'($urandom_range(0, 1023)));
   endtask

   task automatic fetch_at(input logic [FIDX_W-1:0] idx);
      send_item(CMD_FETCH, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
   endtask

   task automatic dma_event(input logic [CMD_W-1:0] cmd);
      send_item(cmd, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                FIDX_W'($urandom_range(0, 1023)));
   endtask

   // Drop valid and hold the sender until every result has been taken.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write the enable register while the block is idle.
   task automatic write_port_enable(input logic value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      port_enabled = value;
   endtask

   // Refused pushes, events on an empty ring, launch, relaunch and completion.
   task automatic test_directed();
      write_port_enable(1'b0);
      send_item(CMD_PUSH, 8'hFF, 1'b1, 10'd0);
      send_item(CMD_DONE, 8'h00, 1'b0, 10'd1023);
      send_item(CMD_ERROR, 8'hFF, 1'b1, 10'd0);
      write_port_enable(1'b1);
      send_item(CMD_PUSH, 8'h00, 1'b0, 10'd0);
      send_item(CMD_PUSH, 8'hFF, 1'b1, 10'd1023);
      // A second call while the DMA is busy only queues its byte.
      send_item(CMD_PUSH, 8'hA5, 1'b1, 10'd0);
      send_item(CMD_FETCH, 8'h00, 1'b0, 10'd0);
      send_item(CMD_FETCH, 8'hFF, 1'b1, 10'd1);
      // The error relaunches from the same tail with the grown length.
      send_item(CMD_ERROR, 8'h00, 1'b0, 10'd0);
      send_item(CMD_FETCH, 8'h00, 1'b0, 10'd2);
      send_item(CMD_DONE, 8'h00, 1'b0, 10'd0);
      // Completion with nothing in flight leaves the tail alone.
      send_item(CMD_DONE, 8'hFF, 1'b1, 10'd1023);
      send_item(CMD_PUSH, 8'h5A, 1'b1, 10'd512);
      send_item(CMD_DONE, 8'h00, 1'b0, 10'd0);
   endtask

   // Fill the ring to its last free slot, overflow it, then drain it.
   task automatic test_full_ring();
      int k;
      while (dma_active) begin
         dma_event(CMD_DONE);
      end
      // No call ends during the fill, so the DMA stays idle.
      while (POS_W'(ring_head + 1'b1) != ring_tail) begin
         push_byte(1'b0);
      end
      push_byte(1'b0);
      // A dropped byte that ends a call still launches a segment.
      push_byte(1'b1);
      for (k = 0; k < 4; k++) begin
         push_byte(1'($urandom_range(0, 1)));
      end
      if (slot_written[RING_SLOTS-1]) begin
         fetch_at(10'd1023);
      end
      if (slot_written[0]) begin
         fetch_at(10'd0);
      end
      k = 0;
      while (dma_active || ring_head != ring_tail) begin
         if (dma_active) begin
            fetch_at(ring_tail);
            fetch_at(POS_W'(ring_tail + active_len - 1'b1));
         end
         dma_event(k == 1 ? CMD_ERROR : CMD_DONE);
         k++;
      end
   endtask

   // Send calls of random length mixed with DMA reads, events and stray items.
   task automatic test_random_traffic(input int n_items);
      int sent;
      int pick;
      int len;
      int k;
      int reads;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++) begin
               push_byte(k == len - 1);
            end
            sent += len;
         end else if (pick < 80 && dma_active) begin
            reads = $urandom_range(0, 3);
            for (k = 0; k < reads; k++) begin
               fetch_at(POS_W'(ring_tail + $urandom_range(0, int'(active_len) - 1)));
            end
            dma_event(($urandom_range(0, 9) == 0) ? CMD_ERROR : CMD_DONE);
            sent += reads + 1;
         end else if (pick < 88) begin
            case ($urandom_range(0, 2))
               0: begin
                  dma_event(CMD_DONE);
               end
               1: begin
                  dma_event(CMD_ERROR);
               end
               default: begin
                  push_byte(1'b0);
               end
            endcase
            sent++;
         end else if (written_slots.size() != 0) begin
            fetch_at(FIDX_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]));
            sent++;
         end else begin
            push_byte(1'b1);
            sent++;
         end
      end
   endtask

   // With the port disabled only pushes are refused; DMA events still act.
   task automatic test_disabled_port();
      write_port_enable(1'b0);
      test_random_traffic(40);
      write_port_enable(1'b1);
   endtask

   // Stall the result side long enough to back up the input, then drain and send DMA completions.
   task automatic test_backpressure();
      int k;
      rsp_hold_cycles = 300;
      for (k = 0; k < 24; k++) begin
         push_byte(k % 6 == 5);
      end
      wait_drained();
      for (k = 0; k < 6; k++) begin
         dma_event(CMD_DONE);
      end
   endtask

   // Compare one result transfer against the oldest expectation.
   task automatic check_result();
      tx_result_type want;
      tx_result_type got;
      got.status        = rsp_chan.status;
      got.dma_start     = rsp_chan.dma_start;
      got.dma_offset    = rsp_chan.dma_offset;
      got.dma_length    = rsp_chan.dma_length;
      got.dropped_total = rsp_chan.dropped_total;
      got.fetched_byte  = rsp_chan.fetched_byte;
      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: result with no request pending: %p", $realtime, got);
         end
      end else begin
         want = expected_results.pop_front();
         if (got.status !== want.status || got.dma_start !== want.dma_start ||
             got.dma_offset !== want.dma_offset || got.dma_length !== want.dma_length ||
             got.dropped_total !== want.dropped_total ||
             got.fetched_byte !== want.fetched_byte) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: result mismatch", $realtime);
               $display("   expected %p", want);
               $display("   actual   %p", got);
            end
         end
      end
   endtask

   // Result side: check each transfer, then pick the next ready value.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            check_result();
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: give up when no transfer happens on either channel for too long.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** tx_ring_dma_segmenter_unit: FAILED **");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      ring_head       = '0;
      ring_tail       = '0;
      dma_active      = 1'b0;
      active_len      = '0;
      drop_count      = '0;
      port_enabled    = 1'b0;
      mismatch_count  = 0;
      rsp_hold_cycles = 0;
      send_idle_pct   = 31;
      recv_idle_pct   = 70;
      for (int i = 0; i < RING_SLOTS; i++) begin
         tx_ring[i]      = '0;
         slot_written[i] = 1'b0;
      end
      reset                 <= 1'b1;
      csr_write_enable      <= 1'b0;
      csr_write_data        <= 1'b0;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= CMD_PUSH;
      req_chan.byte_value   <= '0;
      req_chan.last_of_call <= 1'b0;
      req_chan.fetch_index  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_ring();
      test_random_traffic(180);

      send_idle_pct = 70;
      recv_idle_pct = 31;
      test_disabled_port();
      test_random_traffic(180);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(190);
      test_backpressure();

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("** tx_ring_dma_segmenter_unit: PASSED **");
      end else begin
         $display("** tx_ring_dma_segmenter_unit: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/tdseg_pkg.sv
hw/rtl/tdseg_req_if.sv
hw/rtl/tdseg_rsp_if.sv
hw/rtl/tdseg_ram.sv
hw/rtl/tdseg_front.sv
hw/rtl/tdseg_queue.sv
hw/rtl/tdseg_back.sv
hw/rtl/tx_ring_dma_segmenter_unit.sv
hw/rtl/tdseg_checker.sv
dv/tb.sv
